FILE: rtl/wpi_pkg.sv
package wpi_pkg;

  localparam int COORD_W        = 32;
  localparam int MAX_SEG_POINTS = 31;
  localparam int LENGTH_CHORDS  = 10;
  localparam int J_W            = 5;
  localparam int COEF_W         = 17;
  localparam int OPA_W          = 35;
  localparam int OPB_W          = 33;
  localparam int ACC_W          = 66;
  localparam int DIV_W          = 56;
  localparam int CUR_W          = 36;
  localparam int LEN_W          = 37;
  localparam int SPC_W          = 31;
  localparam int CNT_W          = 6;
  localparam int SQRT_STEPS     = 32;
  localparam int STEP_W         = 6;

  localparam logic [1:0] MODE_LIN    = 2'd0;
  localparam logic [1:0] MODE_PLANAR = 2'd1;
  localparam logic [1:0] MODE_FULL   = 2'd2;
  localparam logic [1:0] MODE_ALIAS  = 2'd3;

  localparam logic       CFG_MODE    = 1'b0;
  localparam logic       CFG_SPACING = 1'b1;

  localparam logic [SPC_W-1:0] SPACING_RESET = 31'd13107;

  typedef enum logic [2:0] {
    SEL_AD = 3'd0,
    SEL_AB = 3'd1,
    SEL_BD = 3'd2,
    SEL_BC = 3'd3,
    SEL_CD = 3'd4
  } seg_sel_t;

  typedef enum logic [4:0] {
    DP_NOP    = 5'd0,
    DP_LOAD   = 5'd1,
    DP_COEF   = 5'd2,
    DP_MUL    = 5'd3,
    DP_ACC    = 5'd4,
    DP_DIVI   = 5'd5,
    DP_DIVS   = 5'd6,
    DP_STORE  = 5'd7,
    DP_CHORD  = 5'd8,
    DP_SQRTI  = 5'd9,
    DP_SQRTS  = 5'd10,
    DP_LENADD = 5'd11,
    DP_CNTI   = 5'd12,
    DP_CNTS   = 5'd13,
    DP_CNTFIX = 5'd14,
    DP_EMIT   = 5'd15,
    DP_FINAL  = 5'd16,
    DP_COMMIT = 5'd17
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    seg_sel_t   sel;
    logic [1:0] axis;
    logic [1:0] term;
    logic       herm;
    logic       sq;
    logic       lin;
    logic       len_ph;
    logic       last;
    logic       pend;
    logic       take_in;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] held;
    logic [1:0] mode;
    logic       fin;
    logic       j_last;
    logic       cnt_done;
    logic       out_free;
  } dp_sts_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
    logic        [COEF_W-1:0] den;
  } coef_t;

  // hermite basis weights scaled by d^3 (doubled denominator), or lerp weights
  function automatic coef_t wpi_coef(input logic [J_W-1:0] j, input logic [J_W-1:0] d,
                                     input logic herm);
    logic signed [20:0] js, ds, j2, j3, d2, d3, a00, a10, a01, a11;
    coef_t res;
    js  = 21'(signed'({1'b0, j}));
    ds  = 21'(signed'({1'b0, d}));
    j2  = js * js;
    j3  = j2 * js;
    d2  = ds * ds;
    d3  = d2 * ds;
    a00 = (j3 <<< 1) - 21'sd3 * (j2 * ds) + d3;
    a10 = j3 - ((j2 * ds) <<< 1) + js * d2;
    a01 = 21'sd3 * (j2 * ds) - (j3 <<< 1);
    a11 = j3 - j2 * ds;
    if (herm) begin
      res.c0  = COEF_W'(a00);
      res.c1  = COEF_W'(a10);
      res.c2  = COEF_W'(a01);
      res.c3  = COEF_W'(a11);
      res.den = COEF_W'(d3 <<< 1);
    end else begin
      res.c0  = COEF_W'(ds - js);
      res.c1  = '0;
      res.c2  = COEF_W'(js);
      res.c3  = '0;
      res.den = COEF_W'(ds);
    end
    return res;
  endfunction

endpackage

FILE: rtl/waypoint_path_interpolator_core.sv
// waypoint path interpolator: turns Q16.16 waypoints into a densified path
// in_* channel takes one waypoint word, in_tlast marks the last waypoint of a path
// out_* channel gives path points; out_tlast closes the run caused by one waypoint,
// out_tuser flags the very last path point and segments whose point count was cut
// cfg_* writes interp_mode (index 0) or point_spacing (index 1), always ready
// one waypoint is in work at a time; in_tready is high only while the block waits
// cost is set by the shared multiplier and the bit-serial divider and square root:
//   each coordinate sample: 4 multiply-accumulates, 56 divide steps
//   each output point: three coordinate samples
//   hermite segment length: 10 chords, a 32-step square root each
//   linear segment length: one chord and its square root, plus the point count
// a waypoint that causes no point goes through plan and commit only, otherwise
// it costs a length estimate per hermite segment plus the samples of each point it produces
// a one-deep output register holds a finished word; when the receiver stalls
// the block waits before writing the next word, nothing is dropped
// reset clears the held waypoint count, the output register and the config
// (mode 1, spacing 13107); no clearing pass is needed
module waypoint_path_interpolator_core
  import wpi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3*COORD_W-1:0] in_tdata,   // way_x, way_y, way_z
  input  logic                 in_tlast,   // final_waypoint
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3*COORD_W-1:0] out_tdata,  // path_x, path_y, path_z
  output logic                 out_tlast,  // run_end
  output logic [1:0]           out_tuser,  // path_end, count_clamped
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [SPC_W-1:0]     cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer for segments, samples, chords and the output handshake
  wpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // window, arithmetic units, config and output register
  wpi_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/wpi_ctrl.sv
module wpi_ctrl
  import wpi_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_PLAN   = 21'h000002,
    S_LOAD   = 21'h000004,
    S_COEF   = 21'h000008,
    S_MUL    = 21'h000010,
    S_ACC    = 21'h000020,
    S_DIVI   = 21'h000040,
    S_DIVS   = 21'h000080,
    S_STORE  = 21'h000100,
    S_CHORD  = 21'h000200,
    S_SQ     = 21'h000400,
    S_SQACC  = 21'h000800,
    S_SQRTI  = 21'h001000,
    S_SQRTS  = 21'h002000,
    S_LENADD = 21'h004000,
    S_CNTI   = 21'h008000,
    S_CNTS   = 21'h010000,
    S_CNTFIX = 21'h020000,
    S_EMIT   = 21'h040000,
    S_FINAL  = 21'h080000,
    S_COMMIT = 21'h100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic [1:0]        term_r, term_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]        segs_left_r, segs_left_nxt;
  logic              second_r, second_nxt;
  seg_sel_t          sel_a_r, sel_a_nxt;
  seg_sel_t          sel_b_r, sel_b_nxt;
  logic              final_r, final_nxt;
  logic              len_ph_r, len_ph_nxt;
  logic              lin, herm_ax, last_pt;

  assign lin     = (sts.mode == MODE_LIN);
  // the length estimate of a hermite segment always runs on the full 3-d curve
  assign herm_ax = len_ph_r || (sts.mode == MODE_FULL) ||
                   ((sts.mode == MODE_PLANAR) && (axis_r != 2'd2));
  assign last_pt = sts.j_last && (segs_left_r == 2'd1) && !final_r;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    term_nxt      = term_r;
    step_nxt      = step_r;
    segs_left_nxt = segs_left_r;
    second_nxt    = second_r;
    sel_a_nxt     = sel_a_r;
    sel_b_nxt     = sel_b_r;
    final_nxt     = final_r;
    len_ph_nxt    = len_ph_r;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.op        = DP_NOP;
    cmd.sel       = second_r ? sel_b_r : sel_a_r;
    cmd.axis      = axis_r;
    cmd.term      = term_r;
    cmd.herm      = herm_ax;
    cmd.lin       = lin;
    cmd.len_ph    = len_ph_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.take_in = in_tvalid;
        if (in_tvalid) state_nxt = S_PLAN;
      end
      S_PLAN: begin
        second_nxt = 1'b0;
        final_nxt  = sts.fin;
        priority if (sts.held == 2'd0) begin
          segs_left_nxt = 2'd0;
          state_nxt     = sts.fin ? S_FINAL : S_COMMIT;
        end else if (lin) begin
          segs_left_nxt = 2'd1;
          sel_a_nxt     = SEL_AD;
          final_nxt     = 1'b0;
          state_nxt     = S_LOAD;
        end else begin
          unique case (sts.held)
            2'd1: begin
              segs_left_nxt = sts.fin ? 2'd1 : 2'd0;
              sel_a_nxt     = SEL_AD;
              state_nxt     = sts.fin ? S_LOAD : S_COMMIT;
            end
            2'd2: begin
              segs_left_nxt = sts.fin ? 2'd2 : 2'd1;
              sel_a_nxt     = SEL_AB;
              sel_b_nxt     = SEL_BD;
              state_nxt     = S_LOAD;
            end
            default: begin
              segs_left_nxt = sts.fin ? 2'd2 : 2'd1;
              sel_a_nxt     = SEL_BC;
              sel_b_nxt     = SEL_CD;
              state_nxt     = S_LOAD;
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.op     = DP_LOAD;
        len_ph_nxt = 1'b1;
        axis_nxt   = 2'd0;
        state_nxt  = lin ? S_CHORD : S_COEF;
      end
      S_COEF: begin
        cmd.op    = DP_COEF;
        term_nxt  = 2'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = DP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = DP_ACC;
        if (term_r == 2'd3) begin
          state_nxt = S_DIVI;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_DIVI: begin
        cmd.op    = DP_DIVI;
        step_nxt  = '0;
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        cmd.op   = DP_DIVS;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(DIV_W - 1)) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op = DP_STORE;
        if (axis_r == 2'd2) begin
          axis_nxt  = 2'd0;
          state_nxt = len_ph_r ? S_CHORD : S_EMIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_COEF;
        end
      end
      S_CHORD: begin
        cmd.op    = DP_CHORD;
        axis_nxt  = 2'd0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op    = DP_MUL;
        cmd.sq    = 1'b1;
        state_nxt = S_SQACC;
      end
      S_SQACC: begin
        cmd.op = DP_ACC;
        if (axis_r == 2'd2) begin
          axis_nxt  = 2'd0;
          state_nxt = S_SQRTI;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_SQRTI: begin
        cmd.op    = DP_SQRTI;
        step_nxt  = '0;
        state_nxt = S_SQRTS;
      end
      S_SQRTS: begin
        cmd.op   = DP_SQRTS;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = S_LENADD;
      end
      S_LENADD: begin
        cmd.op    = DP_LENADD;
        axis_nxt  = 2'd0;
        state_nxt = (lin || sts.j_last) ? S_CNTI : S_COEF;
      end
      S_CNTI: begin
        cmd.op    = DP_CNTI;
        state_nxt = S_CNTS;
      end
      S_CNTS: begin
        if (sts.cnt_done) state_nxt = S_CNTFIX;
        else cmd.op = DP_CNTS;
      end
      S_CNTFIX: begin
        cmd.op     = DP_CNTFIX;
        len_ph_nxt = 1'b0;
        axis_nxt   = 2'd0;
        state_nxt  = S_COEF;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op   = DP_EMIT;
          cmd.last = last_pt;
          cmd.pend = last_pt && sts.fin;
          if (sts.j_last) begin
            segs_left_nxt = segs_left_r - 2'd1;
            if (segs_left_r > 2'd1) begin
              second_nxt = 1'b1;
              state_nxt  = S_LOAD;
            end else begin
              state_nxt = final_r ? S_FINAL : S_COMMIT;
            end
          end else begin
            state_nxt = S_COEF;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.op    = DP_FINAL;
          cmd.last  = 1'b1;
          cmd.pend  = 1'b1;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.op    = DP_COMMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      term_r      <= '0;
      step_r      <= '0;
      segs_left_r <= '0;
      second_r    <= 1'b0;
      sel_a_r     <= SEL_AD;
      sel_b_r     <= SEL_AD;
      final_r     <= 1'b0;
      len_ph_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      term_r      <= term_nxt;
      step_r      <= step_nxt;
      segs_left_r <= segs_left_nxt;
      second_r    <= second_nxt;
      sel_a_r     <= sel_a_nxt;
      sel_b_r     <= sel_b_nxt;
      final_r     <= final_nxt;
      len_ph_r    <= len_ph_nxt;
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_EMIT || cmd.op == DP_FINAL) |-> sts.out_free)
    else $error("word written into a busy output slot");

  a_load_has_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (segs_left_r != 2'd0))
    else $error("segment load without a planned segment");

  a_count_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CNTFIX) |-> $past(sts.cnt_done))
    else $error("point count fixed before the count loop ended");

  a_pend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_EMIT && cmd.pend) |-> (cmd.last && sts.fin))
    else $error("path end flagged on a word that is not the last");

endmodule

FILE: rtl/wpi_dpath.sv
module wpi_dpath
  import wpi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [3*COORD_W-1:0] in_tdata,
  input  logic                 in_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [SPC_W-1:0]     cfg_data,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [3*COORD_W-1:0] out_tdata,
  output logic                 out_tlast,
  output logic [1:0]           out_tuser
);

  logic [1:0]        mode_cfg_r;
  logic [SPC_W-1:0]  spacing_r;

  logic signed [COORD_W-1:0] in_r [3];
  logic                      fin_r;
  logic signed [COORD_W-1:0] wa_r [3];
  logic signed [COORD_W-1:0] wb_r [3];
  logic signed [COORD_W-1:0] wc_r [3];
  logic [1:0]                held_r;
  logic [1:0]                path_mode_r;

  logic signed [COORD_W-1:0] p0_r [3];
  logic signed [COORD_W-1:0] p1_r [3];
  logic signed [COORD_W+1:0] m0_r [3];
  logic signed [COORD_W+1:0] m1_r [3];

  coef_t                     coef_r;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [DIV_W-1:0]          dvd_r;
  logic [COEF_W-1:0]         rem_r;
  logic                      neg_r;
  logic signed [CUR_W-1:0]   cur_r [3];
  logic signed [CUR_W-1:0]   prev_r [3];
  logic [COORD_W-1:0]        cap_r [3];
  logic signed [COORD_W-1:0] pt_r [3];
  logic [63:0]               sv_r, sr_r, sb_r;
  logic [LEN_W-1:0]          len_r;
  logic signed [LEN_W+1:0]   crem_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      clamp_r;
  logic [J_W-1:0]            j_r, d_r;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_pt_r [3];
  logic                      out_last_r, out_pend_r, out_clamp_r;

  // segment operands picked from the window and the new waypoint
  logic signed [COORD_W-1:0] ld_p0 [3];
  logic signed [COORD_W-1:0] ld_p1 [3];
  logic signed [COORD_W+1:0] ld_m0 [3];
  logic signed [COORD_W+1:0] ld_m1 [3];
  logic signed [COORD_W:0]   d_da, d_ba, d_db, d_ca, d_dc;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_da = (COORD_W+1)'(in_r[c]) - (COORD_W+1)'(wa_r[c]);
      d_ba = (COORD_W+1)'(wb_r[c]) - (COORD_W+1)'(wa_r[c]);
      d_db = (COORD_W+1)'(in_r[c]) - (COORD_W+1)'(wb_r[c]);
      d_ca = (COORD_W+1)'(wc_r[c]) - (COORD_W+1)'(wa_r[c]);
      d_dc = (COORD_W+1)'(in_r[c]) - (COORD_W+1)'(wc_r[c]);
      unique case (cmd.sel)
        SEL_AB: begin
          ld_p0[c] = wa_r[c];
          ld_p1[c] = wb_r[c];
          ld_m0[c] = {d_ba, 1'b0};
          ld_m1[c] = (COORD_W+2)'(d_da);
        end
        SEL_BD: begin
          ld_p0[c] = wb_r[c];
          ld_p1[c] = in_r[c];
          ld_m0[c] = (COORD_W+2)'(d_da);
          ld_m1[c] = {d_db, 1'b0};
        end
        SEL_BC: begin
          ld_p0[c] = wb_r[c];
          ld_p1[c] = wc_r[c];
          ld_m0[c] = (COORD_W+2)'(d_ca);
          ld_m1[c] = (COORD_W+2)'(d_db);
        end
        SEL_CD: begin
          ld_p0[c] = wc_r[c];
          ld_p1[c] = in_r[c];
          ld_m0[c] = (COORD_W+2)'(d_db);
          ld_m1[c] = {d_dc, 1'b0};
        end
        default: begin
          ld_p0[c] = wa_r[c];
          ld_p1[c] = in_r[c];
          ld_m0[c] = {d_da, 1'b0};
          ld_m1[c] = {d_da, 1'b0};
        end
      endcase
    end
  end

  // shared multiplier: basis weight times operand, or a capped chord component squared
  logic signed [OPA_W-1:0]   opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [OPA_W+OPB_W-1:0] prod_full;
  logic signed [COORD_W:0]   p0x2, p1x2;

  always_comb begin
    p0x2 = {p0_r[cmd.axis], 1'b0};
    p1x2 = {p1_r[cmd.axis], 1'b0};
    if (cmd.sq) begin
      opa = signed'({3'b000, cap_r[cmd.axis]});
      opb = signed'({1'b0, cap_r[cmd.axis]});
    end else begin
      unique case (cmd.term)
        2'd0: begin
          opa = cmd.herm ? OPA_W'(p0x2) : OPA_W'(p0_r[cmd.axis]);
          opb = OPB_W'(coef_r.c0);
        end
        2'd1: begin
          opa = OPA_W'(m0_r[cmd.axis]);
          opb = OPB_W'(coef_r.c1);
        end
        2'd2: begin
          opa = cmd.herm ? OPA_W'(p1x2) : OPA_W'(p1_r[cmd.axis]);
          opb = OPB_W'(coef_r.c2);
        end
        default: begin
          opa = OPA_W'(m1_r[cmd.axis]);
          opb = OPB_W'(coef_r.c3);
        end
      endcase
    end
  end

  assign prod_full = opa * opb;

  // rounding divider front end and result shaping
  logic [ACC_W-1:0]          acc_mag;
  logic [COEF_W:0]           trial;
  logic signed [DIV_W+1:0]   qs;
  logic signed [COORD_W-1:0] q_sat;

  assign acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign trial   = {rem_r, dvd_r[DIV_W-1]} - {1'b0, coef_r.den};
  assign qs      = neg_r ? -signed'({2'b00, dvd_r}) : signed'({2'b00, dvd_r});

  always_comb begin
    if (qs > (DIV_W+2)'(64'sd2147483647)) q_sat = 32'sh7FFF_FFFF;
    else if (qs < (DIV_W+2)'(-64'sd2147483648)) q_sat = 32'sh8000_0000;
    else q_sat = qs[COORD_W-1:0];
  end

  // chord components, capped in magnitude
  logic signed [CUR_W:0] cdiff [3];
  logic [CUR_W:0]        cmag  [3];
  logic [COORD_W-1:0]    ccap  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cdiff[c] = cmd.lin ? ((CUR_W+1)'(p1_r[c]) - (CUR_W+1)'(p0_r[c]))
                         : ((CUR_W+1)'(cur_r[c]) - (CUR_W+1)'(prev_r[c]));
      cmag[c]  = cdiff[c][CUR_W] ? (CUR_W+1)'(-cdiff[c]) : (CUR_W+1)'(cdiff[c]);
      ccap[c]  = (cmag[c] > (CUR_W+1)'(64'h8000_0000)) ? 32'h8000_0000
                                                         : cmag[c][COORD_W-1:0];
    end
  end

  logic [63:0]      sq_sum;
  logic [SPC_W-1:0] sp_eff;
  logic             cnt_done;

  assign sq_sum   = sr_r + sb_r;
  assign sp_eff   = (spacing_r == '0) ? SPC_W'(1) : spacing_r;
  assign cnt_done = (crem_r <= 0) || (cnt_r > CNT_W'(MAX_SEG_POINTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r  <= MODE_PLANAR;
      spacing_r   <= SPACING_RESET;
      held_r      <= 2'd0;
      path_mode_r <= MODE_PLANAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE:    mode_cfg_r <= cfg_data[1:0];
          CFG_SPACING: spacing_r  <= cfg_data;
          default:     ;
        endcase
      end
      // a new word may be written in the cycle the old one leaves
      if (cmd.op == DP_EMIT || cmd.op == DP_FINAL) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cmd.op == DP_COMMIT) begin
        priority if (fin_r) begin
          held_r <= 2'd0;
        end else if (held_r == 2'd0) begin
          held_r      <= 2'd1;
          path_mode_r <= (mode_cfg_r == MODE_ALIAS) ? MODE_FULL : mode_cfg_r;
        end else if (path_mode_r == MODE_LIN) begin
          held_r <= held_r;
        end else if (held_r != 2'd3) begin
          held_r <= held_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_r[0] <= in_tdata[COORD_W-1:0];
      in_r[1] <= in_tdata[2*COORD_W-1:COORD_W];
      in_r[2] <= in_tdata[3*COORD_W-1:2*COORD_W];
      fin_r   <= in_tlast;
    end
    unique case (cmd.op)
      DP_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          p0_r[c]   <= ld_p0[c];
          p1_r[c]   <= ld_p1[c];
          m0_r[c]   <= ld_m0[c];
          m1_r[c]   <= ld_m1[c];
          prev_r[c] <= CUR_W'(ld_p0[c]);
        end
        len_r <= '0;
        j_r   <= J_W'(1);
        d_r   <= J_W'(LENGTH_CHORDS);
      end
      DP_COEF: begin
        coef_r <= wpi_coef(j_r, d_r, cmd.herm);
        acc_r  <= '0;
      end
      DP_MUL:  prod_r <= prod_full[ACC_W-1:0];
      DP_ACC:  acc_r  <= acc_r + prod_r;
      DP_DIVI: begin
        dvd_r <= acc_mag[DIV_W-1:0] + DIV_W'(coef_r.den >> 1);
        rem_r <= '0;
        neg_r <= acc_r[ACC_W-1];
      end
      DP_DIVS: begin
        if (!trial[COEF_W]) begin
          rem_r <= trial[COEF_W-1:0];
          dvd_r <= {dvd_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[COEF_W-2:0], dvd_r[DIV_W-1]};
          dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
        end
      end
      DP_STORE: begin
        if (cmd.len_ph) cur_r[cmd.axis] <= qs[CUR_W-1:0];
        else pt_r[cmd.axis] <= q_sat;
      end
      DP_CHORD: begin
        for (int c = 0; c < 3; c++) cap_r[c] <= ccap[c];
        acc_r <= '0;
      end
      DP_SQRTI: begin
        sv_r <= acc_r[63:0];
        sr_r <= '0;
        sb_r <= 64'h4000_0000_0000_0000;
      end
      DP_SQRTS: begin
        if (sv_r >= sq_sum) begin
          sv_r <= sv_r - sq_sum;
          sr_r <= (sr_r >> 1) + sb_r;
        end else begin
          sr_r <= sr_r >> 1;
        end
        sb_r <= sb_r >> 2;
      end
      DP_LENADD: begin
        len_r <= len_r + LEN_W'(sr_r[COORD_W:0]);
        for (int c = 0; c < 3; c++) prev_r[c] <= cur_r[c];
        j_r <= j_r + 1'b1;
      end
      DP_CNTI: begin
        crem_r <= signed'({2'b00, len_r});
        cnt_r  <= '0;
      end
      DP_CNTS: begin
        crem_r <= crem_r - (LEN_W+2)'(sp_eff);
        cnt_r  <= cnt_r + 1'b1;
      end
      DP_CNTFIX: begin
        if (cnt_r > CNT_W'(MAX_SEG_POINTS)) begin
          d_r     <= J_W'(MAX_SEG_POINTS - 1);
          clamp_r <= 1'b1;
        end else if (cnt_r < CNT_W'(2)) begin
          d_r     <= J_W'(1);
          clamp_r <= 1'b0;
        end else begin
          d_r     <= J_W'(cnt_r - 1'b1);
          clamp_r <= 1'b0;
        end
        j_r <= '0;
      end
      DP_EMIT: begin
        for (int c = 0; c < 3; c++) out_pt_r[c] <= pt_r[c];
        out_last_r  <= cmd.last;
        out_pend_r  <= cmd.pend;
        out_clamp_r <= clamp_r;
        j_r         <= j_r + 1'b1;
      end
      DP_FINAL: begin
        for (int c = 0; c < 3; c++) out_pt_r[c] <= in_r[c];
        out_last_r  <= cmd.last;
        out_pend_r  <= cmd.pend;
        out_clamp_r <= 1'b0;
      end
      DP_COMMIT: begin
        if (!fin_r) begin
          for (int c = 0; c < 3; c++) begin
            priority if (held_r == 2'd0 || path_mode_r == MODE_LIN) begin
              wa_r[c] <= in_r[c];
            end else if (held_r == 2'd1) begin
              wb_r[c] <= in_r[c];
            end else if (held_r == 2'd2) begin
              wc_r[c] <= in_r[c];
            end else begin
              wa_r[c] <= wb_r[c];
              wb_r[c] <= wc_r[c];
              wc_r[c] <= in_r[c];
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready    = 1'b1;
  assign sts.held     = held_r;
  assign sts.mode     = path_mode_r;
  assign sts.fin      = fin_r;
  assign sts.j_last   = (j_r == d_r);
  assign sts.cnt_done = cnt_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pt_r[2], out_pt_r[1], out_pt_r[0]};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_clamp_r, out_pend_r};

endmodule
